>>> rtl/core/evit_pkg.sv
// Shared types and constants for the event interest table.
package evit_pkg;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_MODIFY = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_NOTIFY = 2'd3
	} cmd_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EXISTS   = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;

	localparam int KEY_W   = 16;
	localparam int MASK_W  = 32;
	localparam int DATA_W  = 64;
	localparam int RDY_W   = 6;
	localparam int BITS_W  = 5;
	localparam int IN_W    = 120;
	localparam int OUT_W   = 88;
	localparam int ONESHOT_BIT = 30;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_LOOK   = 6'b000010,
		S_READ   = 6'b000100,
		S_EXEC   = 6'b001000,
		S_SHRINK = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

	// epoll mask to poll mask; the RDNORM/RDBAND and WRNORM/WRBAND bits fold into IN and OUT
	function automatic logic [BITS_W-1:0] poll_mask_of(input logic [MASK_W-1:0] m);
		logic [BITS_W-1:0] p;
		p[0] = m[0] | m[6] | m[7];
		p[1] = m[1];
		p[2] = m[2] | m[8] | m[9];
		p[3] = m[3];
		p[4] = m[4];
		return p;
	endfunction

endpackage

>>> rtl/core/event_interest_table.sv
// Top level of the event interest table.
// One command transfer in, one result transfer out. The result is offered after the command has
// passed tag match, slot memory read and read-modify-write, and is held until m_tready is high.
// A delete of the highest slot also passes a shrink state that steps the active top down past
// each further free slot. The next command is taken once the result transfer completes.
// No clearing pass is needed after reset.
module event_interest_table #(
	parameter int SLOTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// cmd, fd, event_mask, user_data, readiness
	input  logic [evit_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status, event_valid, event_bits, data_out, slot_used, active_top, zero pad
	output logic [evit_pkg::OUT_W-1:0]    m_tdata
);

	localparam int IW = $clog2(SLOTS);
	localparam int LW = IW + 1;
	localparam int EW = IW + 8;
	localparam int AW = 1 + evit_pkg::BITS_W + LW;

	evit_pkg::state_t              state_q;
	evit_pkg::cmd_t                cmd_q;
	logic [evit_pkg::KEY_W-1:0]    fd_q;
	logic [evit_pkg::MASK_W-1:0]   mask_q;
	logic [evit_pkg::DATA_W-1:0]   ud_q;
	logic [evit_pkg::RDY_W-1:0]    rdy_q;

	logic [LW-1:0] free_top_q, top_q, hwm_q;
	logic [IW-1:0] slot_s2;
	logic [IW-1:0] rd_idx;

	logic [AW-1:0]                 attr_mem [SLOTS];
	logic [evit_pkg::DATA_W-1:0]   data_mem [SLOTS];
	logic [AW-1:0]                 attr_rd;
	logic [evit_pkg::DATA_W-1:0]   data_rd;

	logic hit, probe_valid, wr_en, wr_set;
	logic [IW-1:0] idx, wr_idx, probe_idx;

	logic [2:0]                    status_q;
	logic                          ev_q;
	logic [evit_pkg::BITS_W-1:0]   bits_q;
	logic [evit_pkg::DATA_W-1:0]   dout_q;
	logic [IW-1:0]                 slot_q;

	logic [evit_pkg::BITS_W-1:0]   pm, rev;
	logic                          full;
	logic [EW-1:0]                 slot_ext, top_ext;

	assign s_tready = state_q == evit_pkg::S_IDLE;
	assign m_tvalid = state_q == evit_pkg::S_OUT;
	assign full     = free_top_q == LW'(SLOTS);
	assign probe_idx = IW'(top_q - LW'(1));

	assign rd_idx = (state_q == evit_pkg::S_READ) ?
		((cmd_q == evit_pkg::CMD_ADD && !hit) ? free_top_q[IW-1:0] : idx) : slot_s2;

	assign pm = attr_rd[evit_pkg::BITS_W+LW-1:LW];
	assign rev[0] = rdy_q[0] & pm[0];
	assign rev[1] = rdy_q[1] & pm[1];
	assign rev[2] = rdy_q[2] & pm[2];
	assign rev[3] = rdy_q[3] | rdy_q[5];
	assign rev[4] = rdy_q[4];

	assign wr_en  = state_q == evit_pkg::S_EXEC &&
		((cmd_q == evit_pkg::CMD_ADD && !hit && !full) ||
		 (cmd_q == evit_pkg::CMD_DELETE && hit));
	assign wr_set = cmd_q == evit_pkg::CMD_ADD;
	assign wr_idx = slot_s2;

	evit_match #(.SLOTS(SLOTS), .IW(IW)) u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.fd         (fd_q),
		.wr_en      (wr_en),
		.wr_set     (wr_set),
		.wr_idx     (wr_idx),
		.probe_idx  (probe_idx),
		.probe_valid(probe_valid),
		.hit_q      (hit),
		.idx_q      (idx)
	);

	// slot memories: read in S_READ, written back in S_EXEC
	always_ff @(posedge clk) begin
		attr_rd <= attr_mem[rd_idx];
		data_rd <= data_mem[rd_idx];
		if (state_q == evit_pkg::S_EXEC) begin
			if (cmd_q == evit_pkg::CMD_ADD && !hit && !full) begin
				attr_mem[slot_s2] <= {mask_q[evit_pkg::ONESHOT_BIT],
					evit_pkg::poll_mask_of(mask_q), LW'(0)};
				data_mem[slot_s2] <= ud_q;
			end else if (hit && cmd_q == evit_pkg::CMD_MODIFY) begin
				attr_mem[slot_s2] <= {mask_q[evit_pkg::ONESHOT_BIT],
					evit_pkg::poll_mask_of(mask_q), LW'(0)};
				data_mem[slot_s2] <= ud_q;
			end else if (hit && cmd_q == evit_pkg::CMD_DELETE) begin
				attr_mem[slot_s2] <= {1'b0, {evit_pkg::BITS_W{1'b0}}, free_top_q};
			end else if (hit && cmd_q == evit_pkg::CMD_NOTIFY && rev != '0 &&
				attr_rd[AW-1]) begin
				attr_mem[slot_s2] <= {1'b1, {evit_pkg::BITS_W{1'b0}}, attr_rd[LW-1:0]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q  <= evit_pkg::cmd_t'(s_tdata[1:0]);
			fd_q   <= s_tdata[17:2];
			mask_q <= s_tdata[49:18];
			ud_q   <= s_tdata[113:50];
			rdy_q  <= s_tdata[119:114];
		end
		if (state_q == evit_pkg::S_LOOK) slot_s2 <= '0;
		if (state_q == evit_pkg::S_READ) slot_s2 <= rd_idx;
		if (state_q == evit_pkg::S_EXEC) begin
			if (cmd_q == evit_pkg::CMD_ADD) begin
				ev_q   <= 1'b0;
				bits_q <= '0;
				dout_q <= '0;
				if (hit) begin
					status_q <= evit_pkg::ST_EXISTS;
					slot_q   <= idx;
				end else if (full) begin
					status_q <= evit_pkg::ST_FULL;
					slot_q   <= '0;
				end else begin
					status_q <= evit_pkg::ST_OK;
					slot_q   <= slot_s2;
				end
			end else if (!hit) begin
				status_q <= evit_pkg::ST_NOTFOUND;
				slot_q   <= '0;
				ev_q     <= 1'b0;
				bits_q   <= '0;
				dout_q   <= '0;
			end else begin
				status_q <= evit_pkg::ST_OK;
				slot_q   <= slot_s2;
				if (cmd_q == evit_pkg::CMD_NOTIFY && rev != '0) begin
					ev_q   <= 1'b1;
					bits_q <= rev;
					dout_q <= data_rd;
				end else begin
					ev_q   <= 1'b0;
					bits_q <= '0;
					dout_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= evit_pkg::S_IDLE;
			free_top_q <= '0;
			top_q      <= '0;
			hwm_q      <= '0;
		end else begin
			case (state_q)
				evit_pkg::S_IDLE:   if (s_tvalid) state_q <= evit_pkg::S_LOOK;
				evit_pkg::S_LOOK:   state_q <= evit_pkg::S_READ;
				evit_pkg::S_READ:   state_q <= evit_pkg::S_EXEC;
				evit_pkg::S_EXEC: begin
					if (cmd_q == evit_pkg::CMD_ADD && !hit && !full) begin
						state_q <= evit_pkg::S_OUT;
						if (free_top_q == hwm_q) begin
							free_top_q <= hwm_q + LW'(1);
							hwm_q      <= hwm_q + LW'(1);
						end else begin
							free_top_q <= attr_rd[LW-1:0];
						end
						if (LW'(slot_s2) >= top_q) top_q <= LW'(slot_s2) + LW'(1);
					end else if (cmd_q == evit_pkg::CMD_DELETE && hit) begin
						free_top_q <= LW'(slot_s2);
						if (LW'(slot_s2) + LW'(1) == top_q) begin
							top_q   <= LW'(slot_s2);
							state_q <= evit_pkg::S_SHRINK;
						end else begin
							state_q <= evit_pkg::S_OUT;
						end
					end else begin
						state_q <= evit_pkg::S_OUT;
					end
				end
				evit_pkg::S_SHRINK: begin
					if (top_q != '0 && !probe_valid) top_q <= top_q - LW'(1);
					else state_q <= evit_pkg::S_OUT;
				end
				evit_pkg::S_OUT:    if (m_tready) state_q <= evit_pkg::S_IDLE;
				default:            state_q <= evit_pkg::S_IDLE;
			endcase
		end
	end

	assign slot_ext = EW'(slot_q);
	assign top_ext  = EW'(top_q);
	assign m_tdata  = {2'b00, top_ext[6:0], slot_ext[5:0], dout_q, bits_q, ev_q, status_q};

endmodule

>>> rtl/core/evit_match.sv
// Key tag registers with parallel key match and a valid-bit probe.
module evit_match #(
	parameter int SLOTS = 64,
	parameter int IW    = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [evit_pkg::KEY_W-1:0] fd,
	input  logic                      wr_en,
	input  logic                      wr_set,
	input  logic [IW-1:0]             wr_idx,
	input  logic [IW-1:0]             probe_idx,
	output logic                      probe_valid,
	output logic                      hit_q,
	output logic [IW-1:0]             idx_q
);

	logic [SLOTS-1:0]               valid_q;
	logic [evit_pkg::KEY_W-1:0]     key_q [SLOTS];
	logic                           hit;
	logic [IW-1:0]                  idx;

	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (valid_q[i] && key_q[i] == fd) begin
				hit = 1'b1;
				idx = idx | IW'(i);
			end
		end
	end

	assign probe_valid = valid_q[probe_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			hit_q <= hit;
			idx_q <= idx;
			if (wr_en) valid_q[wr_idx] <= wr_set;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_set) key_q[wr_idx] <= fd;
	end

endmodule

>>> bench/tb_event_interest_table.sv
// Testbench for the event interest table: scoreboard predictor with directed and random command streams.
module tb_event_interest_table;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0]  status;
		logic        ev_valid;
		logic [4:0]  ev_bits;
		logic [63:0] dout;
		logic [5:0]  slot;
		logic [6:0]  top;
	} result_t;

	class table_scoreboard;
		bit          occupied[64];
		logic [15:0] keys[64];
		logic [31:0] masks[64];
		logic [63:0] datas[64];
		logic [4:0]  pmask[64];
		int          link[64];
		int          free_slot;
		int          top_mark;
		result_t     pending[$];
		int          errors;

		function new();
			for (int i = 0; i < 64; i++) begin
				occupied[i] = 0;
				pmask[i] = '0;
				link[i] = i + 1;
				keys[i] = '0;
				masks[i] = '0;
				datas[i] = '0;
			end
			free_slot = 0;
			top_mark = 0;
			errors = 0;
		endfunction

		function int lookup(logic [15:0] fd);
			for (int i = 0; i < 64; i++)
				if (occupied[i] && keys[i] == fd)
					return i;
			return -1;
		endfunction

		function logic [4:0] fold(logic [31:0] m);
			return {m[4], m[3], m[2] | m[8] | m[9], m[1], m[0] | m[6] | m[7]};
		endfunction

		function void note_command(evit_pkg::cmd_t cmd, logic [15:0] fd, logic [31:0] m,
				logic [63:0] ud, logic [5:0] rdy);
			result_t r;
			int f;
			logic [4:0] rev;
			r = '0;
			f = lookup(fd);
			if (cmd == evit_pkg::CMD_ADD) begin
				if (f >= 0) begin
					r.status = evit_pkg::ST_EXISTS;
					r.slot = f[5:0];
				end else if (free_slot >= 64) begin
					r.status = evit_pkg::ST_FULL;
				end else begin
					r.slot = free_slot[5:0];
					f = free_slot;
					free_slot = link[f];
					occupied[f] = 1;
					keys[f] = fd;
					masks[f] = m;
					datas[f] = ud;
					pmask[f] = fold(m);
					if (f >= top_mark)
						top_mark = f + 1;
				end
			end else if (f < 0) begin
				r.status = evit_pkg::ST_NOTFOUND;
			end else begin
				r.slot = f[5:0];
				if (cmd == evit_pkg::CMD_MODIFY) begin
					masks[f] = m;
					datas[f] = ud;
					pmask[f] = fold(m);
				end else if (cmd == evit_pkg::CMD_DELETE) begin
					occupied[f] = 0;
					keys[f] = '0;
					datas[f] = '0;
					pmask[f] = '0;
					link[f] = free_slot;
					free_slot = f;
					if (f + 1 == top_mark)
						while (top_mark > 0 && !occupied[top_mark - 1])
							top_mark--;
				end else begin
					rev = {rdy[4], rdy[3] | rdy[5], rdy[2] & pmask[f][2],
						rdy[1] & pmask[f][1], rdy[0] & pmask[f][0]};
					if (rev != 0) begin
						r.ev_valid = 1;
						r.ev_bits = rev;
						r.dout = datas[f];
						if (masks[f][evit_pkg::ONESHOT_BIT])
							pmask[f] = '0;
					end
				end
			end
			r.top = top_mark[6:0];
			pending.push_back(r);
		endfunction

		function void check_result(logic [evit_pkg::OUT_W-1:0] raw);
			result_t got, exp;
			got.status = raw[2:0];
			got.ev_valid = raw[3];
			got.ev_bits = raw[8:4];
			got.dout = raw[72:9];
			got.slot = raw[78:73];
			got.top = raw[85:79];
			if (pending.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status) begin
				$error("status exp %0d got %0d", exp.status, got.status); errors++;
			end
			if (got.ev_valid !== exp.ev_valid) begin
				$error("event_valid exp %0d got %0d", exp.ev_valid, got.ev_valid); errors++;
			end
			if (got.ev_bits !== exp.ev_bits) begin
				$error("event_bits exp %h got %h", exp.ev_bits, got.ev_bits); errors++;
			end
			if (got.dout !== exp.dout) begin
				$error("data_out exp %h got %h", exp.dout, got.dout); errors++;
			end
			if (got.slot !== exp.slot) begin
				$error("slot_used exp %0d got %0d", exp.slot, got.slot); errors++;
			end
			if (got.top !== exp.top) begin
				$error("active_top exp %0d got %0d", exp.top, got.top); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [evit_pkg::IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [evit_pkg::OUT_W-1:0] m_tdata;
	table_scoreboard sb;
	int cycles = 0;
	logic [15:0] fd_pool[8];

	event_interest_table u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic send_command(evit_pkg::cmd_t cmd, logic [15:0] fd, logic [31:0] m,
			logic [63:0] ud, logic [5:0] rdy);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			s_tvalid <= 0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {rdy, ud, m, fd, cmd};
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		sb.note_command(cmd, fd, m, ud, rdy);
		@(negedge clk);
	endtask

	// per result: wait for it, hold off a drawn number of cycles, then take it
	task automatic take_results();
		int wait_n;
		forever begin
			while (!m_tvalid) @(negedge clk);
			wait_n = $urandom_range(0, 11);
			repeat (wait_n) @(negedge clk);
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
			m_tready <= 0;
		end
	endtask

	function automatic logic [15:0] pick_fd();
		if ($urandom_range(0, 9) < 8)
			return fd_pool[$urandom_range(0, 7)] + 16'($urandom_range(0, 70));
		return 16'($urandom);
	endfunction

	function automatic logic [31:0] pick_mask();
		logic [31:0] m;
		m = $urandom;
		if ($urandom_range(0, 2) != 0)
			m = m & 32'h400003df;
		return m;
	endfunction

	initial begin
		@(negedge clk);
		take_results();
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
		if (cycles > 400000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		sb = new();
		fd_pool = '{16'h0000, 16'h0100, 16'h1000, 16'h4000, 16'h8000, 16'hc000, 16'hff00,
			16'hffb9};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// directed: lookups on empty table, extremes, oneshot, full table, shrink
		send_command(evit_pkg::CMD_NOTIFY, 16'h0000, '0, '0, 6'h3f);
		send_command(evit_pkg::CMD_MODIFY, 16'hffff, '0, '0, '0);
		send_command(evit_pkg::CMD_DELETE, 16'h0000, '0, '0, '0);
		send_command(evit_pkg::CMD_ADD, 16'h0000, 32'hffffffff, 64'hffffffffffffffff, '0);
		send_command(evit_pkg::CMD_ADD, 16'hffff, 32'h40000005, 64'h0123456789abcdef, '0);
		send_command(evit_pkg::CMD_ADD, 16'h0000, '0, '0, '0);
		send_command(evit_pkg::CMD_NOTIFY, 16'hffff, '0, '0, 6'h02);
		send_command(evit_pkg::CMD_NOTIFY, 16'hffff, '0, '0, 6'h05);
		send_command(evit_pkg::CMD_NOTIFY, 16'hffff, '0, '0, 6'h07);
		send_command(evit_pkg::CMD_NOTIFY, 16'hffff, '0, '0, 6'h38);
		send_command(evit_pkg::CMD_MODIFY, 16'hffff, 32'h000003c2, '0, '0);
		send_command(evit_pkg::CMD_NOTIFY, 16'hffff, '0, '0, 6'h3f);
		send_command(evit_pkg::CMD_NOTIFY, 16'h0000, '0, '0, 6'h3f);
		for (int i = 2; i < 64; i++)
			send_command(evit_pkg::CMD_ADD, 16'(i), 32'h1, 64'(i), '0);
		send_command(evit_pkg::CMD_ADD, 16'h7777, '0, '0, '0);
		for (int i = 63; i >= 2; i--)
			send_command(evit_pkg::CMD_DELETE, 16'(i), '0, '0, '0);
		send_command(evit_pkg::CMD_DELETE, 16'h0000, '0, '0, '0);
		send_command(evit_pkg::CMD_DELETE, 16'hffff, '0, '0, '0);
		// random: mostly pool keys so adds, hits and deletes interleave
		for (int n = 0; n < 410; n++) begin
			int k;
			evit_pkg::cmd_t c;
			k = $urandom_range(0, 99);
			c = (k < 35) ? evit_pkg::CMD_ADD : (k < 50) ? evit_pkg::CMD_MODIFY :
				(k < 70) ? evit_pkg::CMD_DELETE : evit_pkg::CMD_NOTIFY;
			send_command(c, pick_fd(), pick_mask(), {$urandom, $urandom}, 6'($urandom));
		end
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

>>> sim.f
rtl/core/evit_pkg.sv
rtl/core/evit_match.sv
rtl/core/event_interest_table.sv
bench/tb_event_interest_table.sv
